/* src/qrm_pkg.sv */
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix package
// Shared widths and constants for the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int IN_WIDTH_DEF = 16;
  localparam int OUT_W        = 16;
  localparam int FRAC_BITS    = 14;
  localparam int LANES        = 9;
  localparam int QUOT_W       = FRAC_BITS + 1;
  localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(1 << FRAC_BITS);

  typedef logic signed [OUT_W-1:0] entry_t;

endpackage

/* src/quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix
// Converts a signed fixed-point quaternion (qx, qy, qz, qw) into the nine
// entries of its 3x3 rotation matrix in signed Q2.14, column-major order.
//
// Usage: drive qx, qy, qz and qw and raise start; a transfer takes place at
// every rising edge where start is high and busy is low. Busy is always low,
// so one quaternion can be taken in every cycle.
// Each result appears on c0r0 .. c2r2 for exactly one cycle with done high.
// From the accepting edge to the done cycle the data passes through one
// stage of products, one stage of sums, a 15-stage restoring divider that
// produces one quotient bit per stage for all nine entries at once, and
// one stage for rounding and clamping. Throughput is one quaternion per
// cycle. The entries are 16384*N/n rounded to nearest with
// ties away from zero, where n is the squared length; a zero quaternion
// gives the identity matrix.
// The synchronous reset clears the valid bits of every stage, so results in
// flight are dropped. The receiver cannot stall this block.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix #(
  parameter int IN_WIDTH = qrm_pkg::IN_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [IN_WIDTH-1:0]    qx,
  input  logic signed [IN_WIDTH-1:0]    qy,
  input  logic signed [IN_WIDTH-1:0]    qz,
  input  logic signed [IN_WIDTH-1:0]    qw,
  output logic                          done,
  output qrm_pkg::entry_t               c0r0,
  output qrm_pkg::entry_t               c0r1,
  output qrm_pkg::entry_t               c0r2,
  output qrm_pkg::entry_t               c1r0,
  output qrm_pkg::entry_t               c1r1,
  output qrm_pkg::entry_t               c1r2,
  output qrm_pkg::entry_t               c2r0,
  output qrm_pkg::entry_t               c2r1,
  output qrm_pkg::entry_t               c2r2
);

  import qrm_pkg::*;

  localparam int EW    = (IN_WIDTH > 31) ? 31 : IN_WIDTH;
  localparam int SH    = IN_WIDTH - EW;
  localparam int PW    = 2 * EW;
  localparam int NW    = PW + 1;
  localparam int STEPS = FRAC_BITS;

  assign busy = 1'b0;

  logic signed [EW-1:0] xs, ys, zs, ws;

  assign xs = EW'(qx >>> SH);
  assign ys = EW'(qy >>> SH);
  assign zs = EW'(qz >>> SH);
  assign ws = EW'(qw >>> SH);

  logic                 v1;
  logic signed [PW-1:0] p_xx, p_yy, p_zz, p_ww, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    p_xx <= xs * xs;
    p_yy <= ys * ys;
    p_zz <= zs * zs;
    p_ww <= ws * ws;
    p_xy <= xs * ys;
    p_xz <= xs * zs;
    p_yz <= ys * zs;
    p_wx <= ws * xs;
    p_wy <= ws * ys;
    p_wz <= ws * zs;
  end

  logic signed [NW:0] e_xx, e_yy, e_zz, e_ww, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
  logic signed [NW:0] numer [LANES];
  logic [NW-1:0]      abs_c [LANES];
  logic [NW-1:0]      den_c;

  always_comb begin
    e_xx = (NW+1)'(p_xx);
    e_yy = (NW+1)'(p_yy);
    e_zz = (NW+1)'(p_zz);
    e_ww = (NW+1)'(p_ww);
    e_xy = (NW+1)'(p_xy);
    e_xz = (NW+1)'(p_xz);
    e_yz = (NW+1)'(p_yz);
    e_wx = (NW+1)'(p_wx);
    e_wy = (NW+1)'(p_wy);
    e_wz = (NW+1)'(p_wz);
    den_c = NW'(e_xx + e_yy + e_zz + e_ww);
    numer[0] = e_xx + e_ww - e_yy - e_zz;
    numer[1] = (e_xy + e_wz) <<< 1;
    numer[2] = (e_xz - e_wy) <<< 1;
    numer[3] = (e_xy - e_wz) <<< 1;
    numer[4] = e_yy + e_ww - e_xx - e_zz;
    numer[5] = (e_yz + e_wx) <<< 1;
    numer[6] = (e_xz + e_wy) <<< 1;
    numer[7] = (e_yz - e_wx) <<< 1;
    numer[8] = e_zz + e_ww - e_xx - e_yy;
    for (int i = 0; i < LANES; i++) begin
      abs_c[i] = numer[i][NW] ? NW'(-numer[i]) : NW'(numer[i]);
    end
  end

  logic              v2;
  logic              zero2;
  logic [NW-1:0]     den2;
  logic [NW-1:0]     abs2 [LANES];
  logic [LANES-1:0]  neg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    den2  <= den_c;
    zero2 <= (den_c == '0);
    for (int i = 0; i < LANES; i++) begin
      abs2[i] <= abs_c[i];
      neg2[i] <= numer[i][NW];
    end
  end

  logic              dv   [STEPS+1];
  logic              dzero[STEPS+1];
  logic [NW-1:0]     dden [STEPS+1];
  logic [LANES-1:0]  dneg [STEPS+1];
  logic [NW-1:0]     drem [STEPS+1][LANES];
  logic [QUOT_W-1:0] dquo [STEPS+1][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= v2;
    end
    dzero[0] <= zero2;
    dden[0]  <= den2;
    dneg[0]  <= neg2;
    for (int i = 0; i < LANES; i++) begin
      if (abs2[i] >= den2) begin
        drem[0][i] <= abs2[i] - den2;
        dquo[0][i] <= QUOT_W'(1);
      end else begin
        drem[0][i] <= abs2[i];
        dquo[0][i] <= '0;
      end
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [NW:0] twice [LANES];
    logic        ge    [LANES];

    always_comb begin
      for (int i = 0; i < LANES; i++) begin
        twice[i] = {drem[k][i], 1'b0};
        ge[i]    = twice[i] >= {1'b0, dden[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else begin
        dv[k+1] <= dv[k];
      end
      dzero[k+1] <= dzero[k];
      dden[k+1]  <= dden[k];
      dneg[k+1]  <= dneg[k];
      for (int i = 0; i < LANES; i++) begin
        drem[k+1][i] <= ge[i] ? NW'(twice[i] - {1'b0, dden[k]}) : NW'(twice[i]);
        dquo[k+1][i] <= {dquo[k][i][QUOT_W-2:0], ge[i]};
      end
    end
  end

  logic [NW:0]      f_twice [LANES];
  logic [OUT_W-1:0] f_mag   [LANES];
  entry_t           f_val   [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      f_twice[i] = {drem[STEPS][i], 1'b0};
      f_mag[i]   = OUT_W'(dquo[STEPS][i]) +
                   OUT_W'(f_twice[i] >= {1'b0, dden[STEPS]});
      if (f_mag[i] > OUT_ONE) begin
        f_mag[i] = OUT_ONE;
      end
      f_val[i] = dneg[STEPS][i] ? entry_t'(-f_mag[i]) : entry_t'(f_mag[i]);
      if (dzero[STEPS]) begin
        f_val[i] = (i == 0 || i == 4 || i == 8) ? entry_t'(OUT_ONE) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[STEPS];
    end
    c0r0 <= f_val[0];
    c0r1 <= f_val[1];
    c0r2 <= f_val[2];
    c1r0 <= f_val[3];
    c1r1 <= f_val[4];
    c1r2 <= f_val[5];
    c2r0 <= f_val[6];
    c2r1 <= f_val[7];
    c2r2 <= f_val[8];
  end

endmodule

/* tb/tb_quaternion_to_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// Quaternion to rotation matrix testbench
// Sends quaternions through the command interface and compares every matrix
// against an exact rational predictor with round-half-away-from-zero.
// ----------------------------------------------------------------------------
module tb_quaternion_to_rotation_matrix;
  import qrm_pkg::*;

  localparam int IN_W      = 16;
  localparam int LATENCY   = 18;
  localparam int MAX_CYCLES = 400000;

  typedef struct {
    entry_t e [LANES];
  } matrix_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [IN_W-1:0] qx, qy, qz, qw;
  logic done;
  entry_t c0r0, c0r1, c0r2, c1r0, c1r1, c1r2, c2r0, c2r1, c2r2;

  matrix_t pending_matrices [$];
  int mismatch_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int zero_count = 0;
  longint cycle_count = 0;

  quaternion_to_rotation_matrix #(.IN_WIDTH(IN_W)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .qx(qx), .qy(qy), .qz(qz), .qw(qw), .done(done),
    .c0r0(c0r0), .c0r1(c0r1), .c0r2(c0r2),
    .c1r0(c1r0), .c1r1(c1r1), .c1r2(c1r2),
    .c2r0(c2r0), .c2r1(c2r1), .c2r2(c2r2)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("FAIL quaternion_to_rotation_matrix");
      $finish;
    end
  end

  function automatic entry_t q14_ratio(longint num, longint den);
    longint mag, q, r;
    mag = (num < 0) ? -num : num;
    q = (mag * 16384) / den;
    r = (mag * 16384) % den;
    if (2 * r >= den) q = q + 1;
    if (q > 16384) q = 16384;
    return entry_t'((num < 0) ? -q : q);
  endfunction

  function automatic matrix_t rotation_of(longint x, longint y, longint z, longint w);
    matrix_t m;
    longint n;
    n = x*x + y*y + z*z + w*w;
    if (n == 0) begin
      foreach (m.e[i]) m.e[i] = '0;
      m.e[0] = OUT_ONE;
      m.e[4] = OUT_ONE;
      m.e[8] = OUT_ONE;
      return m;
    end
    m.e[0] = q14_ratio(x*x + w*w - y*y - z*z, n);
    m.e[1] = q14_ratio(2 * (x*y + w*z), n);
    m.e[2] = q14_ratio(2 * (x*z - w*y), n);
    m.e[3] = q14_ratio(2 * (x*y - w*z), n);
    m.e[4] = q14_ratio(y*y + w*w - x*x - z*z, n);
    m.e[5] = q14_ratio(2 * (y*z + w*x), n);
    m.e[6] = q14_ratio(2 * (x*z + w*y), n);
    m.e[7] = q14_ratio(2 * (y*z - w*x), n);
    m.e[8] = q14_ratio(z*z + w*w - x*x - y*y, n);
    return m;
  endfunction

  task automatic report_mismatch(string what, int lane, entry_t got, entry_t want);
    $display("Mismatch on %s lane %0d: got %0d, expected %0d.", what, lane, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    matrix_t got, want;
    if (!rst && done) begin
      got.e = '{c0r0, c0r1, c0r2, c1r0, c1r1, c1r2, c2r0, c2r1, c2r2};
      if (pending_matrices.size() == 0) begin
        report_mismatch("unexpected result", 0, got.e[0], '0);
      end else begin
        want = pending_matrices.pop_front();
        checked_count++;
        for (int i = 0; i < LANES; i++)
          if (got.e[i] !== want.e[i]) report_mismatch("matrix entry", i, got.e[i], want.e[i]);
      end
    end
  end

  int burst_left = 0;

  // One transfer; start stays high across a burst and drops only in a gap.
  task automatic send_quaternion(logic signed [IN_W-1:0] x, y, z, w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    qx <= x;
    qy <= y;
    qz <= z;
    qw <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_matrices.push_back(rotation_of(x, y, z, w));
    if (x == 0 && y == 0 && z == 0 && w == 0) zero_count++;
    sent_count++;
    burst_left--;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_matrices.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] pick_component();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return IN_W'($signed($urandom_range(0, 15)) - 8);
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [IN_W-1:0] corners [5] = '{16'sh8000, 16'sh7fff, 0, 1, -1};
    send_quaternion(0, 0, 0, 0);
    send_quaternion(0, 0, 0, 16'sh7fff);
    send_quaternion(16'sh7fff, 0, 0, 0);
    send_quaternion(0, 16'sh8000, 0, 0);
    send_quaternion(0, 0, 16'sh7fff, 0);
    send_quaternion(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quaternion(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quaternion(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_quaternion(1, 0, 0, 0);
    send_quaternion(0, 0, 0, -1);
    send_quaternion(1, 1, 1, 1);
    send_quaternion(1, -1, 1, 0);
    for (int i = 0; i < 10; i++)
      send_quaternion(corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)],
                      corners[$urandom_range(0, 4)], corners[$urandom_range(0, 4)]);
  endtask

  task automatic test_random_stream(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_quaternion(pick_component(), pick_component(), pick_component(), pick_component());
      else
        send_quaternion(IN_W'($urandom), IN_W'($urandom), IN_W'($urandom), IN_W'($urandom));
    end
  endtask

  task automatic test_back_to_back(int count);
    burst_left = count;
    test_random_stream(count);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    qx = '0;
    qy = '0;
    qz = '0;
    qw = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    drain_results();
    test_random_stream(900);
    drain_results();
    test_back_to_back(100);
    test_random_stream(930);
    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d quaternions (%0d zero), checked %0d matrices.",
             sent_count, zero_count, checked_count);
    if (mismatch_count == 0 && pending_matrices.size() == 0) begin
      $display("PASS quaternion_to_rotation_matrix");
    end else begin
      $display("FAIL quaternion_to_rotation_matrix");
    end
    $finish;
  end

endmodule
